// ----- src/point_in_triangle_barycentric_assert.svh -----
// Assertion macros for the point-in-triangle block.
// Expect clk and arst_n in the scope of use; no other dependencies.
`ifndef POINT_IN_TRIANGLE_BARYCENTRIC_ASSERT_SVH
`define POINT_IN_TRIANGLE_BARYCENTRIC_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PITB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PITB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pitb_pkg.sv -----
// Package for the point-in-triangle block: default widths and the flag struct.
// No dependencies.
`timescale 1ns / 1ps

package pitb_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int WEIGHT_FRAC_DEF = 16;
	localparam int WEIGHT_WIDTH    = 24;
	localparam int QUOT_BITS       = 24;

	// Per-transaction flags carried alongside the divider chain.
	typedef struct packed {
		logic neg_u;
		logic neg_v;
		logic ovf_u;
		logic ovf_v;
		logic degen;
		logic contained;
	} pitb_flags_t;

endpackage

// ----- src/pitb_div_cell.sv -----
// One restoring-division cell: settles one quotient bit for both weights.
// Depends on pitb_pkg.
`timescale 1ns / 1ps

module pitb_div_cell import pitb_pkg::*; #(
	parameter int RW   = 64,
	parameter int DENW = 40,
	parameter int QB   = 24,
	parameter int BIT  = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [RW-1:0]   in_rem_u,
	input  logic [RW-1:0]   in_rem_v,
	input  logic [QB-1:0]   in_q_u,
	input  logic [QB-1:0]   in_q_v,
	input  logic [DENW-1:0] in_den,
	input  pitb_flags_t     in_flags,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [RW-1:0]   out_rem_u,
	output logic [RW-1:0]   out_rem_v,
	output logic [QB-1:0]   out_q_u,
	output logic [QB-1:0]   out_q_v,
	output logic [DENW-1:0] out_den,
	output pitb_flags_t     out_flags
);

	logic            valid_q;
	logic [RW-1:0]   rem_u_q, rem_v_q;
	logic [QB-1:0]   q_u_q, q_v_q;
	logic [DENW-1:0] den_q;
	pitb_flags_t     flags_q;
	logic [RW:0]     dsh, trial_u, trial_v;

	assign in_ready = !valid_q || out_ready;
	assign dsh      = (RW + 1)'(in_den) << BIT;
	assign trial_u  = {1'b0, in_rem_u} - dsh;
	assign trial_v  = {1'b0, in_rem_v} - dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Subtract the shifted divisor where it fits, and set this quotient bit.
	always_ff @(posedge clk) begin
		if (in_ready) begin
			rem_u_q <= trial_u[RW] ? in_rem_u : trial_u[RW-1:0];
			rem_v_q <= trial_v[RW] ? in_rem_v : trial_v[RW-1:0];
			q_u_q   <= in_q_u | (QB'(!trial_u[RW]) << BIT);
			q_v_q   <= in_q_v | (QB'(!trial_v[RW]) << BIT);
			den_q   <= in_den;
			flags_q <= in_flags;
		end
	end

	assign out_valid = valid_q;
	assign out_rem_u = rem_u_q;
	assign out_rem_v = rem_v_q;
	assign out_q_u   = q_u_q;
	assign out_q_v   = q_v_q;
	assign out_den   = den_q;
	assign out_flags = flags_q;

endmodule

// ----- src/pitb_div_chain.sv -----
// Row of division cells, most significant quotient bit first.
// Depends on pitb_pkg and pitb_div_cell.
`timescale 1ns / 1ps

module pitb_div_chain import pitb_pkg::*; #(
	parameter int RW   = 64,
	parameter int DENW = 40,
	parameter int QB   = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [RW-1:0]   in_rem_u,
	input  logic [RW-1:0]   in_rem_v,
	input  logic [DENW-1:0] in_den,
	input  pitb_flags_t     in_flags,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [RW-1:0]   out_rem_u,
	output logic [RW-1:0]   out_rem_v,
	output logic [QB-1:0]   out_q_u,
	output logic [QB-1:0]   out_q_v,
	output pitb_flags_t     out_flags
);

	logic            vld [QB+1];
	logic            rdy [QB+1];
	logic [RW-1:0]   rem_u [QB+1];
	logic [RW-1:0]   rem_v [QB+1];
	logic [QB-1:0]   q_u [QB+1];
	logic [QB-1:0]   q_v [QB+1];
	logic [DENW-1:0] den [QB+1];
	pitb_flags_t     fl [QB+1];

	assign vld[0]   = in_valid;
	assign in_ready = rdy[0];
	assign rem_u[0] = in_rem_u;
	assign rem_v[0] = in_rem_v;
	assign q_u[0]   = '0;
	assign q_v[0]   = '0;
	assign den[0]   = in_den;
	assign fl[0]    = in_flags;

	for (genvar g = 0; g < QB; g++) begin : g_cell
		pitb_div_cell #(.RW(RW), .DENW(DENW), .QB(QB), .BIT(QB - 1 - g)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[g]),
			.in_ready  (rdy[g]),
			.in_rem_u  (rem_u[g]),
			.in_rem_v  (rem_v[g]),
			.in_q_u    (q_u[g]),
			.in_q_v    (q_v[g]),
			.in_den    (den[g]),
			.in_flags  (fl[g]),
			.out_valid (vld[g+1]),
			.out_ready (rdy[g+1]),
			.out_rem_u (rem_u[g+1]),
			.out_rem_v (rem_v[g+1]),
			.out_q_u   (q_u[g+1]),
			.out_q_v   (q_v[g+1]),
			.out_den   (den[g+1]),
			.out_flags (fl[g+1])
		);
	end

	assign rdy[QB]   = out_ready;
	assign out_valid = vld[QB];
	assign out_rem_u = rem_u[QB];
	assign out_rem_v = rem_v[QB];
	assign out_q_u   = q_u[QB];
	assign out_q_v   = q_v[QB];
	assign out_flags = fl[QB];

endmodule

// ----- src/point_in_triangle_barycentric.sv -----
// Top level of the barycentric point-in-triangle test.
// Depends on pitb_pkg, pitb_div_chain and point_in_triangle_barycentric_assert.svh.
`timescale 1ns / 1ps
`include "point_in_triangle_barycentric_assert.svh"

// One transaction carries a triangle (a, b, c) and a query point, all signed
// fixed point; one result transaction returns the weights u (vertex c),
// v (vertex b) and w = 1 - u - v (vertex a) with WEIGHT_FRAC_BITS fraction bits,
// rounded toward minus infinity and saturated to 24 bits, plus the inside and
// degenerate flags. A new transaction is taken every cycle unless the output
// stalls. The pipeline has five arithmetic stages (edge vectors, dot products,
// products of dot products, numerators and denominator, sign and scaling), one
// stage per quotient bit in the 24-cell divider chain, and the output register.
// Each stage holds only while it is full and the next one is blocked, so bubbles
// are squeezed out and input is taken while a result waits at the output.
module point_in_triangle_barycentric import pitb_pkg::*; #(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] vert_a_x,
	input  logic signed [COORD_WIDTH-1:0] vert_a_y,
	input  logic signed [COORD_WIDTH-1:0] vert_a_z,
	input  logic signed [COORD_WIDTH-1:0] vert_b_x,
	input  logic signed [COORD_WIDTH-1:0] vert_b_y,
	input  logic signed [COORD_WIDTH-1:0] vert_b_z,
	input  logic signed [COORD_WIDTH-1:0] vert_c_x,
	input  logic signed [COORD_WIDTH-1:0] vert_c_y,
	input  logic signed [COORD_WIDTH-1:0] vert_c_z,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [WEIGHT_WIDTH-1:0] weight_u,
	output logic signed [WEIGHT_WIDTH-1:0] weight_v,
	output logic signed [WEIGHT_WIDTH-1:0] weight_w,
	output logic                          inside_res,
	output logic                          degenerate
);

	localparam int EW   = COORD_WIDTH + 1;        // edge vector component
	localparam int DW   = 2 * EW + 2;             // dot product
	localparam int PW   = 2 * DW;                 // product of dot products
	localparam int NW   = PW + 1;                 // numerators and denominator
	localparam int DENW = PW;                     // denominator, known nonnegative
	localparam int RW   = DENW + QUOT_BITS;       // divider remainder
	localparam int SHW  = NW + WEIGHT_FRAC_BITS;  // scaled numerator magnitude
	localparam int CMPW = (SHW > RW) ? SHW : RW;
	localparam int WW   = WEIGHT_WIDTH;
	localparam int SW   = WW + 2;                 // room for 1 - u - v

	localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW - 1){1'b1}}};
	localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW - 1){1'b0}}};
	localparam logic signed [SW-1:0] ONE_W = SW'(1) << WEIGHT_FRAC_BITS;
	localparam logic [QUOT_BITS:0]   NEG_LIMIT = (QUOT_BITS + 1)'(1) << (WW - 1);

	// Stage handshake: a stage takes new data when empty or when its
	// successor is taking its current contents.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic chain_ready, chain_valid, rdy_o;

	assign rdy5     = !v_s5 || chain_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: edge vectors e0 = c - a, e1 = b - a, e2 = p - a.
	logic signed [EW-1:0] a_ext [3];
	logic signed [EW-1:0] b_ext [3];
	logic signed [EW-1:0] c_ext [3];
	logic signed [EW-1:0] p_ext [3];
	logic signed [EW-1:0] e0_s1 [3];
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];

	assign a_ext[0] = EW'(vert_a_x);
	assign a_ext[1] = EW'(vert_a_y);
	assign a_ext[2] = EW'(vert_a_z);
	assign b_ext[0] = EW'(vert_b_x);
	assign b_ext[1] = EW'(vert_b_y);
	assign b_ext[2] = EW'(vert_b_z);
	assign c_ext[0] = EW'(vert_c_x);
	assign c_ext[1] = EW'(vert_c_y);
	assign c_ext[2] = EW'(vert_c_z);
	assign p_ext[0] = EW'(point_x);
	assign p_ext[1] = EW'(point_y);
	assign p_ext[2] = EW'(point_z);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int k = 0; k < 3; k++) begin
				e0_s1[k] <= c_ext[k] - a_ext[k];
				e1_s1[k] <= b_ext[k] - a_ext[k];
				e2_s1[k] <= p_ext[k] - a_ext[k];
			end
		end
	end

	// Stage 2: the five dot products.
	logic signed [DW-1:0] d00_s2, d01_s2, d02_s2, d11_s2, d12_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			d00_s2 <= e0_s1[0] * e0_s1[0] + e0_s1[1] * e0_s1[1] + e0_s1[2] * e0_s1[2];
			d01_s2 <= e0_s1[0] * e1_s1[0] + e0_s1[1] * e1_s1[1] + e0_s1[2] * e1_s1[2];
			d02_s2 <= e0_s1[0] * e2_s1[0] + e0_s1[1] * e2_s1[1] + e0_s1[2] * e2_s1[2];
			d11_s2 <= e1_s1[0] * e1_s1[0] + e1_s1[1] * e1_s1[1] + e1_s1[2] * e1_s1[2];
			d12_s2 <= e1_s1[0] * e2_s1[0] + e1_s1[1] * e2_s1[1] + e1_s1[2] * e2_s1[2];
		end
	end

	// Stage 3: products feeding denominator and both numerators.
	logic signed [PW-1:0] pd0_s3, pd1_s3, pu0_s3, pu1_s3, pv0_s3, pv1_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			pd0_s3 <= d00_s2 * d11_s2;
			pd1_s3 <= d01_s2 * d01_s2;
			pu0_s3 <= d11_s2 * d02_s2;
			pu1_s3 <= d01_s2 * d12_s2;
			pv0_s3 <= d00_s2 * d12_s2;
			pv1_s3 <= d01_s2 * d02_s2;
		end
	end

	// Stage 4: den, nu, nv.
	logic signed [NW-1:0] den_s4, nu_s4, nv_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			den_s4 <= NW'(pd0_s3) - NW'(pd1_s3);
			nu_s4  <= NW'(pu0_s3) - NW'(pu1_s3);
			nv_s4  <= NW'(pv0_s3) - NW'(pv1_s3);
		end
	end

	// Stage 5: split sign from magnitude, scale the magnitudes, flag a
	// quotient too large for the chain, and settle the inside test exactly.
	logic [NW-1:0]       mag_u, mag_v;
	logic [SHW-1:0]      sh_u, sh_v;
	logic [DENW-1:0]     den_mag;
	logic [CMPW-1:0]     den_top;
	logic signed [NW:0]  nsum;
	logic                degen_c;
	pitb_flags_t         flags_c, flags_s5;
	logic [RW-1:0]       rem_u_s5, rem_v_s5;
	logic [DENW-1:0]     den_s5;

	assign degen_c = den_s4[NW-1] || (den_s4 == '0);
	assign mag_u   = nu_s4[NW-1] ? $unsigned(-nu_s4) : $unsigned(nu_s4);
	assign mag_v   = nv_s4[NW-1] ? $unsigned(-nv_s4) : $unsigned(nv_s4);
	assign sh_u    = SHW'(mag_u) << WEIGHT_FRAC_BITS;
	assign sh_v    = SHW'(mag_v) << WEIGHT_FRAC_BITS;
	assign den_mag = den_s4[DENW-1:0];
	assign den_top = CMPW'(den_mag) << QUOT_BITS;
	assign nsum    = (NW + 1)'(nu_s4) + (NW + 1)'(nv_s4);

	always_comb begin
		flags_c.neg_u     = nu_s4[NW-1];
		flags_c.neg_v     = nv_s4[NW-1];
		flags_c.ovf_u     = CMPW'(sh_u) >= den_top;
		flags_c.ovf_v     = CMPW'(sh_v) >= den_top;
		flags_c.degen     = degen_c;
		flags_c.contained = !degen_c && !nu_s4[NW-1] && !nv_s4[NW-1]
			&& (nsum < (NW + 1)'(den_s4));
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			flags_s5 <= flags_c;
			rem_u_s5 <= RW'(sh_u);
			rem_v_s5 <= RW'(sh_v);
			den_s5   <= den_mag;
		end
	end

	// Divider chain: one cell per quotient bit, both weights side by side.
	logic [RW-1:0]        rem_u_c, rem_v_c;
	logic [QUOT_BITS-1:0] q_u_c, q_v_c;
	pitb_flags_t          flags_d;

	pitb_div_chain #(.RW(RW), .DENW(DENW), .QB(QUOT_BITS)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (chain_ready),
		.in_rem_u  (rem_u_s5),
		.in_rem_v  (rem_v_s5),
		.in_den    (den_s5),
		.in_flags  (flags_s5),
		.out_valid (chain_valid),
		.out_ready (rdy_o),
		.out_rem_u (rem_u_c),
		.out_rem_v (rem_v_c),
		.out_q_u   (q_u_c),
		.out_q_v   (q_v_c),
		.out_flags (flags_d)
	);

	// Apply the sign: a negative weight rounds its magnitude up so the result
	// is the floor; saturate either way.
	function automatic logic signed [WW-1:0] signed_weight(
		input logic [QUOT_BITS-1:0] q,
		input logic                 rem_nz,
		input logic                 neg,
		input logic                 ovf
	);
		logic [QUOT_BITS:0]   qr;
		logic signed [WW-1:0] res;
		qr = (QUOT_BITS + 1)'(q) + (QUOT_BITS + 1)'(rem_nz);
		if (!neg) begin
			res = (ovf || q[WW-1]) ? W_MAX : WW'(q);
		end else begin
			res = (ovf || (qr > NEG_LIMIT)) ? W_MIN : -WW'(qr);
		end
		return res;
	endfunction

	logic signed [WW-1:0] u_c, v_c, w_c;
	logic signed [SW-1:0] w_full;

	always_comb begin
		u_c    = signed_weight(q_u_c, |rem_u_c, flags_d.neg_u, flags_d.ovf_u);
		v_c    = signed_weight(q_v_c, |rem_v_c, flags_d.neg_v, flags_d.ovf_v);
		w_full = ONE_W - SW'(u_c) - SW'(v_c);
		if (w_full > SW'(W_MAX)) begin
			w_c = W_MAX;
		end else if (w_full < SW'(W_MIN)) begin
			w_c = W_MIN;
		end else begin
			w_c = WW'(w_full);
		end
		if (flags_d.degen) begin
			u_c = '0;
			v_c = '0;
			w_c = '0;
		end
	end

	// Output register: hold while the consumer stalls.
	logic                 out_valid_q;
	logic signed [WW-1:0] weight_u_q, weight_v_q, weight_w_q;
	logic                 inside_q, degen_q;

	assign rdy_o = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= chain_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			weight_u_q <= u_c;
			weight_v_q <= v_c;
			weight_w_q <= w_c;
			inside_q   <= flags_d.contained;
			degen_q    <= flags_d.degen;
		end
	end

	assign out_valid  = out_valid_q;
	assign weight_u   = weight_u_q;
	assign weight_v   = weight_v_q;
	assign weight_w   = weight_w_q;
	assign inside_res = inside_q;
	assign degenerate = degen_q;

	// A degenerate triangle reports zero weights and never contains the point.
	`PITB_ASSERT_NOW(a_degen_clean, out_valid && degenerate, !inside_res && weight_u == '0 && weight_v == '0 && weight_w == '0, "degenerate result not cleared")
	// Containment needs nonnegative u and v and a strictly positive w.
	`PITB_ASSERT_NOW(a_inside_weights, out_valid && inside_res, !weight_u[WW-1] && !weight_v[WW-1] && !weight_w[WW-1] && weight_w != '0, "inside flag disagrees with weights")
	// An accepted transaction always lands in the first stage.
	`PITB_ASSERT_NEXT(a_take_lands, in_valid && in_ready, v_s1, "accepted transaction lost at entry")

endmodule
